### hw/rtl/ox_pkg.sv
// shared constants, types and helpers for the order crossover block
`timescale 1ns / 1ps
`default_nettype none

package ox_pkg;

  localparam int MAX_CITIES = 64;
  localparam int CITY_AW    = $clog2(MAX_CITIES);
  localparam int LEN_W      = CITY_AW + 1;
  localparam int GENE_W     = 6;
  localparam int GENE_SPACE = 1 << GENE_W;
  localparam int CUT_W      = 6;
  localparam int POS_W      = 6;
  localparam int CFG_W      = 7;
  localparam int LEN_MIN    = 4;
  localparam int LEN_RESET  = 64;
  localparam int BANKS      = 2;
  localparam int PAR_DEPTH  = BANKS * MAX_CITIES;
  localparam int PAR_AW     = $clog2(PAR_DEPTH);
  localparam int JOB_DEPTH  = 2;
  localparam int JOB_PW     = $clog2(JOB_DEPTH);
  localparam int JOB_CW     = $clog2(JOB_DEPTH + 1);

  typedef struct packed {
    logic             bad;
    logic             bank;
    logic [CUT_W-1:0] lo;
    logic [CUT_W-1:0] hi;
  } ox_job_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } ox_release_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEG_RD,
    S_SEG_WR,
    S_FILL_RD,
    S_FILL_WR,
    S_EMIT_RD,
    S_EMIT_WR,
    S_BAD
  } ox_state_e;

  // step a tour index by one, wrapping at the tour length
  function automatic logic [CITY_AW-1:0] wrap_inc(input logic [CITY_AW-1:0] p,
                                                  input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] nxt;
    nxt = LEN_W'(p) + LEN_W'(1);
    return (nxt == len) ? '0 : nxt[CITY_AW-1:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/ox_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module ox_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### hw/rtl/ox_front.sv
// load front end: stores parent pairs into a bank and classifies the cut points
`timescale 1ns / 1ps
`default_nettype none

module ox_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [ox_pkg::LEN_W-1:0]   len_i,
  input  wire logic                       in_valid_i,
  output      logic                       in_stall_o,
  input  wire logic [ox_pkg::GENE_W-1:0]  gene_first_i,
  input  wire logic [ox_pkg::GENE_W-1:0]  gene_second_i,
  input  wire logic [ox_pkg::CUT_W-1:0]   cut_low_i,
  input  wire logic [ox_pkg::CUT_W-1:0]   cut_high_i,
  output      logic                       par_we_o,
  output      logic [ox_pkg::PAR_AW-1:0]  par_waddr_o,
  output      logic [ox_pkg::GENE_W-1:0]  par1_wdata_o,
  output      logic [ox_pkg::GENE_W-1:0]  par2_wdata_o,
  output      logic                       job_push_o,
  output      ox_pkg::ox_job_t            job_o,
  input  wire logic                       job_full_i,
  input  wire ox_pkg::ox_release_t        release_i
);

  logic [ox_pkg::CITY_AW-1:0] load_count_q, load_count_d;
  logic                       bank_q, bank_d;
  logic [ox_pkg::BANKS-1:0]   busy_q, busy_d;
  logic                       accept;
  logic                       final_item;
  logic                       cut_ok;

  assign in_stall_o = busy_q[bank_q] || job_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign final_item = (ox_pkg::LEN_W'(load_count_q) + ox_pkg::LEN_W'(1)) >= len_i;
  assign cut_ok     = (cut_low_i != '0) && (cut_low_i < cut_high_i) &&
                      ((ox_pkg::LEN_W'(cut_high_i) + ox_pkg::LEN_W'(2)) <= len_i);

  assign par_we_o     = accept;
  assign par_waddr_o  = {bank_q, load_count_q};
  assign par1_wdata_o = gene_first_i;
  assign par2_wdata_o = gene_second_i;

  assign job_push_o = accept && final_item;
  assign job_o.bad  = !cut_ok;
  assign job_o.bank = bank_q;
  assign job_o.lo   = cut_low_i;
  assign job_o.hi   = cut_high_i;

  always_comb begin
    load_count_d = load_count_q;
    bank_d       = bank_q;
    busy_d       = busy_q;
    if (release_i.valid) begin
      busy_d[release_i.bank] = 1'b0;
    end
    if (accept) begin
      if (final_item) begin
        load_count_d = '0;
        if (cut_ok) begin
          busy_d[bank_q] = 1'b1;
          bank_d         = !bank_q;
        end
      end else begin
        load_count_d = load_count_q + ox_pkg::CITY_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_count_q <= '0;
      bank_q       <= 1'b0;
      busy_q       <= '0;
    end else begin
      load_count_q <= load_count_d;
      bank_q       <= bank_d;
      busy_q       <= busy_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ox_job_fifo.sv
// short queue of classified crossover jobs between front and back
`timescale 1ns / 1ps
`default_nettype none

module ox_job_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire ox_pkg::ox_job_t job_i,
  output      logic            full_o,
  input  wire logic            pop_i,
  output      ox_pkg::ox_job_t job_o,
  output      logic            empty_o
);

  ox_pkg::ox_job_t            slot_q [ox_pkg::JOB_DEPTH];
  logic [ox_pkg::JOB_PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [ox_pkg::JOB_CW-1:0]  count_q;
  logic                       do_push, do_pop;

  assign full_o  = count_q == ox_pkg::JOB_CW'(ox_pkg::JOB_DEPTH);
  assign empty_o = count_q == '0;
  assign job_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == ox_pkg::JOB_PW'(ox_pkg::JOB_DEPTH - 1)) ? '0
                  : wr_ptr_q + ox_pkg::JOB_PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == ox_pkg::JOB_PW'(ox_pkg::JOB_DEPTH - 1)) ? '0
                  : rd_ptr_q + ox_pkg::JOB_PW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + ox_pkg::JOB_CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - ox_pkg::JOB_CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ox_back.sv
// crossover back end: marks segments, fills both children and emits results
`timescale 1ns / 1ps
`default_nettype none

module ox_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [ox_pkg::LEN_W-1:0]   len_i,
  input  wire logic                       job_empty_i,
  input  wire ox_pkg::ox_job_t            job_i,
  output      logic                       job_pop_o,
  output      ox_pkg::ox_release_t        release_o,
  output      logic [ox_pkg::PAR_AW-1:0]  par_raddr_o,
  input  wire logic [ox_pkg::GENE_W-1:0]  par1_rdata_i,
  input  wire logic [ox_pkg::GENE_W-1:0]  par2_rdata_i,
  output      logic                       out_valid_o,
  input  wire logic                       out_stall_i,
  output      logic [ox_pkg::POS_W-1:0]   position_o,
  output      logic [ox_pkg::GENE_W-1:0]  child_first_o,
  output      logic [ox_pkg::GENE_W-1:0]  child_second_o,
  output      logic                       last_o,
  output      logic                       bad_cuts_o
);

  ox_pkg::ox_state_e state_q, state_d;
  ox_pkg::ox_job_t   job_q, job_d;

  logic [ox_pkg::CITY_AW-1:0]    idx_q, idx_d;
  logic [ox_pkg::LEN_W-1:0]      cnt_q, cnt_d;
  logic [ox_pkg::CITY_AW-1:0]    slot1_q, slot1_d, slot2_q, slot2_d;
  logic [ox_pkg::LEN_W-1:0]      fill1_q, fill1_d, fill2_q, fill2_d;
  logic [ox_pkg::LEN_W-1:0]      free_q, free_d;
  logic [ox_pkg::GENE_SPACE-1:0] mark1_q, mark1_d, mark2_q, mark2_d;
  logic [ox_pkg::MAX_CITIES-1:0] flag1_q, flag1_d, flag2_q, flag2_d;

  logic                        c1_we, c2_we;
  logic [ox_pkg::CITY_AW-1:0]  c1_waddr, c2_waddr;
  logic [ox_pkg::GENE_W-1:0]   c1_wdata, c2_wdata;
  logic [ox_pkg::GENE_W-1:0]   c1_rdata, c2_rdata;

  logic [ox_pkg::GENE_W-1:0]   g1, g2;
  logic [ox_pkg::LEN_W-1:0]    len_m1;
  logic                        out_free;
  logic                        take1, take2;

  logic                        out_load;
  logic [ox_pkg::POS_W-1:0]    out_pos;
  logic [ox_pkg::GENE_W-1:0]   out_c1, out_c2;
  logic                        out_last, out_bad;

  logic                        out_valid_q;
  logic [ox_pkg::POS_W-1:0]    pos_q;
  logic [ox_pkg::GENE_W-1:0]   oc1_q, oc2_q;
  logic                        last_q, bad_q;

  assign g1          = par1_rdata_i;
  assign g2          = par2_rdata_i;
  assign len_m1      = len_i - ox_pkg::LEN_W'(1);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign par_raddr_o = {job_q.bank, idx_q};
  assign take1       = !mark2_q[g1] && (fill1_q < free_q);
  assign take2       = !mark1_q[g2] && (fill2_q < free_q);

  ox_ram #(.WIDTH(ox_pkg::GENE_W), .DEPTH(ox_pkg::MAX_CITIES)) u_child1_ram (
    .clk_i   (clk_i),
    .we_i    (c1_we),
    .waddr_i (c1_waddr),
    .wdata_i (c1_wdata),
    .raddr_i (idx_q),
    .rdata_o (c1_rdata)
  );

  ox_ram #(.WIDTH(ox_pkg::GENE_W), .DEPTH(ox_pkg::MAX_CITIES)) u_child2_ram (
    .clk_i   (clk_i),
    .we_i    (c2_we),
    .waddr_i (c2_waddr),
    .wdata_i (c2_wdata),
    .raddr_i (idx_q),
    .rdata_o (c2_rdata)
  );

  always_comb begin
    state_d   = state_q;
    job_d     = job_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    slot1_d   = slot1_q;
    slot2_d   = slot2_q;
    fill1_d   = fill1_q;
    fill2_d   = fill2_q;
    free_d    = free_q;
    mark1_d   = mark1_q;
    mark2_d   = mark2_q;
    flag1_d   = flag1_q;
    flag2_d   = flag2_q;
    job_pop_o = 1'b0;
    release_o = '{valid: 1'b0, bank: job_q.bank};
    c1_we     = 1'b0;
    c2_we     = 1'b0;
    c1_waddr  = idx_q;
    c2_waddr  = idx_q;
    c1_wdata  = g2;
    c2_wdata  = g1;
    out_load  = 1'b0;
    out_pos   = '0;
    out_c1    = '0;
    out_c2    = '0;
    out_last  = 1'b0;
    out_bad   = 1'b0;

    unique case (state_q)
      ox_pkg::S_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          idx_d     = ox_pkg::CITY_AW'(job_i.lo);
          slot1_d   = ox_pkg::CITY_AW'(job_i.hi);
          slot2_d   = ox_pkg::CITY_AW'(job_i.hi);
          fill1_d   = '0;
          fill2_d   = '0;
          cnt_d     = '0;
          free_d    = len_i - (ox_pkg::LEN_W'(job_i.hi) - ox_pkg::LEN_W'(job_i.lo));
          mark1_d   = '0;
          mark2_d   = '0;
          flag1_d   = '0;
          flag2_d   = '0;
          state_d   = job_i.bad ? ox_pkg::S_BAD : ox_pkg::S_SEG_RD;
        end
      end
      ox_pkg::S_SEG_RD: begin
        state_d = ox_pkg::S_SEG_WR;
      end
      ox_pkg::S_SEG_WR: begin
        // segment: child one takes parent two's gene, child two the mirror
        mark1_d[g1]    = 1'b1;
        mark2_d[g2]    = 1'b1;
        c1_we          = 1'b1;
        c2_we          = 1'b1;
        flag1_d[idx_q] = 1'b1;
        flag2_d[idx_q] = 1'b1;
        if ((ox_pkg::LEN_W'(idx_q) + ox_pkg::LEN_W'(1)) == ox_pkg::LEN_W'(job_q.hi)) begin
          idx_d   = ox_pkg::CITY_AW'(job_q.hi);
          state_d = ox_pkg::S_FILL_RD;
        end else begin
          idx_d   = idx_q + ox_pkg::CITY_AW'(1);
          state_d = ox_pkg::S_SEG_RD;
        end
      end
      ox_pkg::S_FILL_RD: begin
        state_d = ox_pkg::S_FILL_WR;
      end
      ox_pkg::S_FILL_WR: begin
        if (take1) begin
          c1_we            = 1'b1;
          c1_waddr         = slot1_q;
          c1_wdata         = g1;
          flag1_d[slot1_q] = 1'b1;
          slot1_d          = ox_pkg::wrap_inc(slot1_q, len_i);
          fill1_d          = fill1_q + ox_pkg::LEN_W'(1);
        end
        if (take2) begin
          c2_we            = 1'b1;
          c2_waddr         = slot2_q;
          c2_wdata         = g2;
          flag2_d[slot2_q] = 1'b1;
          slot2_d          = ox_pkg::wrap_inc(slot2_q, len_i);
          fill2_d          = fill2_q + ox_pkg::LEN_W'(1);
        end
        if (cnt_q == len_m1) begin
          release_o.valid = 1'b1;
          idx_d           = '0;
          state_d         = ox_pkg::S_EMIT_RD;
        end else begin
          cnt_d   = cnt_q + ox_pkg::LEN_W'(1);
          idx_d   = ox_pkg::wrap_inc(idx_q, len_i);
          state_d = ox_pkg::S_FILL_RD;
        end
      end
      ox_pkg::S_EMIT_RD: begin
        state_d = ox_pkg::S_EMIT_WR;
      end
      ox_pkg::S_EMIT_WR: begin
        if (out_free) begin
          out_load = 1'b1;
          out_pos  = ox_pkg::POS_W'(idx_q);
          out_c1   = flag1_q[idx_q] ? c1_rdata : '0;
          out_c2   = flag2_q[idx_q] ? c2_rdata : '0;
          out_last = ox_pkg::LEN_W'(idx_q) == len_m1;
          if (out_last) begin
            state_d = ox_pkg::S_IDLE;
          end else begin
            idx_d   = idx_q + ox_pkg::CITY_AW'(1);
            state_d = ox_pkg::S_EMIT_RD;
          end
        end
      end
      ox_pkg::S_BAD: begin
        if (out_free) begin
          out_load = 1'b1;
          out_last = 1'b1;
          out_bad  = 1'b1;
          state_d  = ox_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ox_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ox_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q   <= job_d;
    idx_q   <= idx_d;
    cnt_q   <= cnt_d;
    slot1_q <= slot1_d;
    slot2_q <= slot2_d;
    fill1_q <= fill1_d;
    fill2_q <= fill2_d;
    free_q  <= free_d;
    mark1_q <= mark1_d;
    mark2_q <= mark2_d;
    flag1_q <= flag1_d;
    flag2_q <= flag2_d;
    if (out_load) begin
      pos_q  <= out_pos;
      oc1_q  <= out_c1;
      oc2_q  <= out_c2;
      last_q <= out_last;
      bad_q  <= out_bad;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign position_o     = pos_q;
  assign child_first_o  = oc1_q;
  assign child_second_o = oc2_q;
  assign last_o         = last_q;
  assign bad_cuts_o     = bad_q;

endmodule

`default_nettype wire

### hw/rtl/order_crossover.sv
// order crossover top level: tour length register, parent banks, front, queue, back
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one parent gene pair per item,
//   position 0 first. The item that completes the tour carries cut_low_i and
//   cut_high_i. Loading runs at one item per cycle while in_stall_o is low.
//   Output channel (out_valid_o / out_stall_i) then gives one result per tour
//   position, 0 to length-1, with last_o on the final one; rejected cuts give a
//   single result with bad_cuts_o and last_o set and all other fields zero.
//   After the final load item, the back end marks the segments and fills both
//   children, then gives the results one by one, paced by the registered read of
//   the child memories.
//   Parents go into two banks, so the next tour loads while the back end still
//   works on the previous one; loading stalls only when both banks or the two
//   entry job queue are taken.
//   The user must write tour_length via cfg_we_i / cfg_wdata_i only while idle,
//   which the block does not enforce; values below 4 act as 4 and above 64 as 64.
//   Reset clears the load position, the queue and the output valid, and sets
//   tour_length to 64. A stalled result holds until taken; the back end waits.
`timescale 1ns / 1ps
`default_nettype none

module order_crossover (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [ox_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output      logic                       in_stall_o,
  input  wire logic [ox_pkg::GENE_W-1:0]  gene_first_i,
  input  wire logic [ox_pkg::GENE_W-1:0]  gene_second_i,
  input  wire logic [ox_pkg::CUT_W-1:0]   cut_low_i,
  input  wire logic [ox_pkg::CUT_W-1:0]   cut_high_i,
  output      logic                       out_valid_o,
  input  wire logic                       out_stall_i,
  output      logic [ox_pkg::POS_W-1:0]   position_o,
  output      logic [ox_pkg::GENE_W-1:0]  child_first_o,
  output      logic [ox_pkg::GENE_W-1:0]  child_second_o,
  output      logic                       last_o,
  output      logic                       bad_cuts_o
);

  logic [ox_pkg::CFG_W-1:0]   tour_length_q;
  logic [ox_pkg::LEN_W-1:0]   len;

  logic                       par_we;
  logic [ox_pkg::PAR_AW-1:0]  par_waddr, par_raddr;
  logic [ox_pkg::GENE_W-1:0]  par1_wdata, par2_wdata, par1_rdata, par2_rdata;

  logic                       job_push, job_pop, job_full, job_empty;
  ox_pkg::ox_job_t            job_in, job_out;
  ox_pkg::ox_release_t        release_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tour_length_q <= ox_pkg::CFG_W'(ox_pkg::LEN_RESET);
    end else if (cfg_we_i) begin
      tour_length_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (tour_length_q < ox_pkg::CFG_W'(ox_pkg::LEN_MIN)) begin
      len = ox_pkg::LEN_W'(ox_pkg::LEN_MIN);
    end else if (tour_length_q > ox_pkg::CFG_W'(ox_pkg::MAX_CITIES)) begin
      len = ox_pkg::LEN_W'(ox_pkg::MAX_CITIES);
    end else begin
      len = ox_pkg::LEN_W'(tour_length_q);
    end
  end

  ox_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .len_i         (len),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .gene_first_i  (gene_first_i),
    .gene_second_i (gene_second_i),
    .cut_low_i     (cut_low_i),
    .cut_high_i    (cut_high_i),
    .par_we_o      (par_we),
    .par_waddr_o   (par_waddr),
    .par1_wdata_o  (par1_wdata),
    .par2_wdata_o  (par2_wdata),
    .job_push_o    (job_push),
    .job_o         (job_in),
    .job_full_i    (job_full),
    .release_i     (release_s)
  );

  ox_ram #(.WIDTH(ox_pkg::GENE_W), .DEPTH(ox_pkg::PAR_DEPTH)) u_parent1_ram (
    .clk_i   (clk_i),
    .we_i    (par_we),
    .waddr_i (par_waddr),
    .wdata_i (par1_wdata),
    .raddr_i (par_raddr),
    .rdata_o (par1_rdata)
  );

  ox_ram #(.WIDTH(ox_pkg::GENE_W), .DEPTH(ox_pkg::PAR_DEPTH)) u_parent2_ram (
    .clk_i   (clk_i),
    .we_i    (par_we),
    .waddr_i (par_waddr),
    .wdata_i (par2_wdata),
    .raddr_i (par_raddr),
    .rdata_o (par2_rdata)
  );

  ox_job_fifo u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .job_o   (job_out),
    .empty_o (job_empty)
  );

  ox_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .len_i          (len),
    .job_empty_i    (job_empty),
    .job_i          (job_out),
    .job_pop_o      (job_pop),
    .release_o      (release_s),
    .par_raddr_o    (par_raddr),
    .par1_rdata_i   (par1_rdata),
    .par2_rdata_i   (par2_rdata),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .position_o     (position_o),
    .child_first_o  (child_first_o),
    .child_second_o (child_second_o),
    .last_o         (last_o),
    .bad_cuts_o     (bad_cuts_o)
  );

endmodule

`default_nettype wire

### hw/rtl/ox_checker.sv
// port level checks for the order crossover block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module ox_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      out_valid_o,
  input wire logic                      out_stall_i,
  input wire logic [ox_pkg::POS_W-1:0]  position_o,
  input wire logic [ox_pkg::GENE_W-1:0] child_first_o,
  input wire logic [ox_pkg::GENE_W-1:0] child_second_o,
  input wire logic                      last_o,
  input wire logic                      bad_cuts_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(position_o) &&
    $stable(child_first_o) && $stable(child_second_o) && $stable(last_o) &&
    $stable(bad_cuts_o))
    else $error("stalled item changed");

  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_cuts_o |-> last_o)
    else $error("bad cuts item without last");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_cuts_o |-> position_o == '0 && child_first_o == '0 &&
    child_second_o == '0)
    else $error("bad cuts item carries data");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o && !bad_cuts_o |->
    position_o >= ox_pkg::POS_W'(ox_pkg::LEN_MIN - 1))
    else $error("tour ended too early");

endmodule

bind order_crossover ox_checker u_ox_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .position_o     (position_o),
  .child_first_o  (child_first_o),
  .child_second_o (child_second_o),
  .last_o         (last_o),
  .bad_cuts_o     (bad_cuts_o)
);

`default_nettype wire
